@@ hdl/gss_pkg.sv @@
package gss_pkg;

	localparam int BW_W = 40;
	localparam int CRIT_W = 48;
	localparam int STEP_W = BW_W + 1;
	localparam int SUM_W = BW_W + 3;
	localparam int ITER_W = 7;
	localparam int R_SHIFT = 16;
	localparam logic [R_SHIFT-1:0] R_NUM = 16'd40503;
	localparam int EPS_LSB = 7;
	localparam int OQ_DEPTH = 3;
	localparam int OQ_CNT_W = 2;

	localparam logic signed [CRIT_W-1:0] CRIT_MAX = {1'b0, {(CRIT_W-1){1'b1}}};

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_ANSWER = 1'b1;

	localparam logic [1:0] ST_SUCCESS = 2'd0;
	localparam logic [1:0] ST_FAILED = 2'd1;
	localparam logic [1:0] ST_TERM = 2'd2;

	localparam logic [1:0] CFG_LOWER = 2'd0;
	localparam logic [1:0] CFG_UPPER = 2'd1;
	localparam logic [1:0] CFG_ADAPT = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_INIT_A = 2'd1,
		PH_INIT_B = 2'd2,
		PH_LOOP = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PROBE = 3'd0,
		KIND_OPTIMUM = 3'd1,
		KIND_STOPPED = 3'd2,
		KIND_TERM = 3'd3,
		KIND_INVALID = 3'd4
	} out_kind_t;

	typedef struct packed {
		logic req_type;
		logic signed [CRIT_W-1:0] criterion_value;
		logic criterion_finite;
		logic [1:0] eval_status;
	} in_item_t;

	typedef struct packed {
		out_kind_t out_kind;
		logic probe_slot;
		logic [BW_W-1:0] bandwidth;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [BW_W-1:0] lower_bound;
		logic [BW_W-1:0] upper_bound;
		logic adaptive_mode;
	} cfg_regs_t;

	typedef struct packed {
		logic [1:0] n;
		out_item_t item0;
		out_item_t item1;
	} push_t;

endpackage

@@ hdl/golden_section_search_driver.sv @@
// A result item enters the registered result queue when its causing item is accepted.
// Throughput: one answer item per cycle while the queue has room and out_stall is low;
// a start item queues two probe items, limited by the three-entry result queue.
// Criterion compares, the 40x16 step multiply and the probe adders are combinational.
// Reset (async, active low): bounds and adaptive mode to zero, search idle,
// criteria to the largest value, result queue empty.
module golden_section_search_driver #(
	parameter int MAX_ITER = 100,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gss_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output gss_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [gss_pkg::BW_W-1:0] cfg_data
);
	import gss_pkg::*;

	cfg_regs_t cfg_q;
	push_t push;
	logic [OQ_CNT_W-1:0] q_count;
	logic [OQ_CNT_W:0] need;
	logic in_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWER: cfg_q.lower_bound <= cfg_data;
				CFG_UPPER: cfg_q.upper_bound <= cfg_data;
				CFG_ADAPT: cfg_q.adaptive_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		need = (in_data.req_type == REQ_START) ? (OQ_CNT_W+1)'(2) : (OQ_CNT_W+1)'(1);
		in_stall = ({1'b0, q_count} + need) > (OQ_CNT_W+1)'(OQ_DEPTH);
		in_accept = in_valid && !in_stall;
	end

	gss_core #(
		.MAX_ITER(MAX_ITER),
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_accept),
		.in_data(in_data),
		.cfg(cfg_q),
		.push(push)
	);

	gss_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data(out_data),
		.count(q_count)
	);

`ifndef SYNTHESIS
	a_start_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_data.req_type == REQ_START |=> out_valid)
		else $error("start item produced no result");

	a_final_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind != KIND_PROBE |-> !out_data.probe_slot && out_data.last)
		else $error("final result with probe slot or without last");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while result queue is empty");
`endif

endmodule

@@ hdl/gss_outq.sv @@
module gss_outq (
	input logic clk,
	input logic arst_n,
	input gss_pkg::push_t push,
	input logic out_stall,
	output logic out_valid,
	output gss_pkg::out_item_t out_data,
	output logic [gss_pkg::OQ_CNT_W-1:0] count
);
	import gss_pkg::*;

	out_item_t ent_q [OQ_DEPTH];
	out_item_t ent_d [OQ_DEPTH];
	logic [OQ_CNT_W-1:0] cnt_q;
	logic [OQ_CNT_W:0] cnt_d;
	logic [OQ_CNT_W:0] base;
	logic pop;

	always_comb begin
		pop = (cnt_q != '0) && !out_stall;
		base = {1'b0, cnt_q} - {{OQ_CNT_W{1'b0}}, pop};
		for (int i = 0; i < OQ_DEPTH; i++) begin
			if (pop && (i < OQ_DEPTH - 1)) begin
				ent_d[i] = ent_q[(i < OQ_DEPTH - 1) ? i + 1 : i];
			end else begin
				ent_d[i] = ent_q[i];
			end
			if ((push.n != 2'd0) && (base == (OQ_CNT_W+1)'(i))) begin
				ent_d[i] = push.item0;
			end
			if ((push.n == 2'd2) && (base + 1'b1 == (OQ_CNT_W+1)'(i))) begin
				ent_d[i] = push.item1;
			end
		end
		cnt_d = base + {1'b0, push.n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d[OQ_CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < OQ_DEPTH; i++) begin
			ent_q[i] <= ent_d[i];
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_data = ent_q[0];
	assign count = cnt_q;

endmodule

@@ hdl/gss_core.sv @@
module gss_core #(
	parameter int MAX_ITER = 100,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input gss_pkg::in_item_t in_data,
	input gss_pkg::cfg_regs_t cfg,
	output gss_pkg::push_t push
);
	import gss_pkg::*;

	localparam logic [SUM_W-1:0] UNIT = SUM_W'(1) << FRAC_BITS;
	localparam logic [SUM_W-1:0] HALF = UNIT >> 1;
	localparam logic [SUM_W-1:0] FRAC_MASK = ~(UNIT - SUM_W'(1));
	localparam logic [SUM_W-1:0] BW_LIMIT = {{(SUM_W-BW_W){1'b0}}, {BW_W{1'b1}}};

	function automatic logic [BW_W-1:0] to_floor(logic signed [SUM_W-1:0] v, logic adapt);
		logic [SUM_W-1:0] u;
		u = v[SUM_W-1] ? '0 : v;
		if (adapt) begin
			u = u & FRAC_MASK;
		end
		return u[BW_W-1:0];
	endfunction

	function automatic logic [BW_W-1:0] to_round(logic signed [SUM_W-1:0] v, logic adapt);
		logic [SUM_W-1:0] u;
		u = v[SUM_W-1] ? '0 : v;
		if (adapt) begin
			u = (u + HALF) & FRAC_MASK;
			if (u > BW_LIMIT) begin
				u = u - UNIT;
			end
		end
		return u[BW_W-1:0];
	endfunction

	phase_t phase_q, phase_d;
	logic [BW_W-1:0] p1_q, p2_q;
	logic signed [CRIT_W-1:0] c1_q, c2_q;
	logic signed [STEP_W-1:0] step_q;
	logic [ITER_W-1:0] iter_q;
	logic [1:0] s1_q, s2_q;
	logic pend_q;

	logic is_start;
	logic signed [CRIT_W-1:0] crit_in, c1_e, c2_e;
	logic [1:0] st_in, s1_e, s2_e;
	logic [ITER_W-1:0] iter_e;

	logic signed [STEP_W-1:0] mul_in, mul_abs, step_new, step_abs;
	logic [BW_W-1:0] mul_mag;
	logic [BW_W+R_SHIFT-1:0] mul_prod;
	logic [BW_W-1:0] mul_res;
	logic signed [SUM_W-1:0] step_x, floor_arg, round_arg;
	logic [BW_W-1:0] floor_res, round_res;

	logic signed [CRIT_W:0] crit_diff, crit_abs;
	logic one_lt, both_ok, any_term, init_inv, pass, decide_en, advance;

	always_comb begin
		is_start = (in_data.req_type == REQ_START);
		crit_in = in_data.criterion_finite ? in_data.criterion_value : CRIT_MAX;
		st_in = (in_data.eval_status == ST_SUCCESS || in_data.eval_status == ST_TERM) ?
			in_data.eval_status : ST_FAILED;

		c1_e = c1_q;
		c2_e = c2_q;
		s1_e = s1_q;
		s2_e = s2_q;
		iter_e = iter_q;
		case (phase_q)
			PH_INIT_A: begin
				c1_e = crit_in;
				s1_e = st_in;
			end
			PH_INIT_B: begin
				c2_e = crit_in;
				s2_e = st_in;
			end
			PH_LOOP: begin
				if (!pend_q) begin
					c1_e = crit_in;
					s1_e = st_in;
				end else begin
					c2_e = crit_in;
					s2_e = st_in;
				end
				iter_e = iter_q + 1'b1;
			end
			default: ;
		endcase

		// step scaling by R, truncated toward zero
		mul_in = is_start ?
			($signed({1'b0, cfg.upper_bound}) - $signed({1'b0, cfg.lower_bound})) : step_q;
		mul_abs = mul_in[STEP_W-1] ? -mul_in : mul_in;
		mul_mag = mul_abs[BW_W-1:0];
		mul_prod = (BW_W+R_SHIFT)'(mul_mag) * (BW_W+R_SHIFT)'(R_NUM);
		mul_res = mul_prod[BW_W+R_SHIFT-1:R_SHIFT];
		step_new = mul_in[STEP_W-1] ? -$signed({1'b0, mul_res}) : $signed({1'b0, mul_res});

		step_x = {{(SUM_W-STEP_W){step_new[STEP_W-1]}}, step_new};
		if (is_start) begin
			floor_arg = $signed({{(SUM_W-BW_W){1'b0}}, cfg.lower_bound}) + step_x;
			round_arg = $signed({{(SUM_W-BW_W){1'b0}}, cfg.upper_bound}) - step_x;
		end else begin
			floor_arg = $signed({{(SUM_W-BW_W){1'b0}}, p1_q}) - step_x;
			round_arg = $signed({{(SUM_W-BW_W){1'b0}}, p2_q}) + step_x;
		end
		floor_res = to_floor(floor_arg, cfg.adaptive_mode);
		round_res = to_round(round_arg, cfg.adaptive_mode);

		step_abs = step_q[STEP_W-1] ? -step_q : step_q;
		crit_diff = $signed({c2_e[CRIT_W-1], c2_e}) - $signed({c1_e[CRIT_W-1], c1_e});
		crit_abs = crit_diff[CRIT_W] ? -crit_diff : crit_diff;
		one_lt = (c1_e < c2_e);
		both_ok = (s1_e == ST_SUCCESS) && (s2_e == ST_SUCCESS);
		any_term = (s1_e == ST_TERM) || (s2_e == ST_TERM);
		init_inv = (c1_q == CRIT_MAX) && (crit_in == CRIT_MAX);
		pass = both_ok && (step_abs > STEP_W'(EPS_LSB)) &&
			(crit_abs > (CRIT_W+1)'(EPS_LSB)) && (iter_e < ITER_W'(MAX_ITER));
		decide_en = !is_start &&
			((phase_q == PH_INIT_B && !any_term && !init_inv) || phase_q == PH_LOOP);
		advance = decide_en && pass;
	end

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (is_start) begin
				phase_d = PH_INIT_A;
			end else begin
				case (phase_q)
					PH_INIT_A: phase_d = PH_INIT_B;
					PH_INIT_B, PH_LOOP: phase_d = advance ? PH_LOOP : PH_IDLE;
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		push.n = 2'd0;
		push.item0 = '{out_kind: KIND_PROBE, probe_slot: 1'b0, bandwidth: floor_res, last: 1'b0};
		push.item1 = '{out_kind: KIND_PROBE, probe_slot: 1'b1, bandwidth: round_res, last: 1'b1};
		if (accept) begin
			if (is_start) begin
				push.n = 2'd2;
			end else if (phase_q == PH_INIT_B && any_term) begin
				push.n = 2'd1;
				push.item0 = '{out_kind: KIND_TERM, probe_slot: 1'b0, bandwidth: '0, last: 1'b1};
			end else if (phase_q == PH_INIT_B && init_inv) begin
				push.n = 2'd1;
				push.item0 = '{out_kind: KIND_INVALID, probe_slot: 1'b0, bandwidth: '0,
					last: 1'b1};
			end else if (decide_en) begin
				push.n = 2'd1;
				if (pass && one_lt) begin
					push.item0 = '{out_kind: KIND_PROBE, probe_slot: 1'b0, bandwidth: round_res,
						last: 1'b1};
				end else if (pass) begin
					push.item0 = '{out_kind: KIND_PROBE, probe_slot: 1'b1, bandwidth: floor_res,
						last: 1'b1};
				end else if (both_ok) begin
					push.item0 = '{out_kind: KIND_OPTIMUM, probe_slot: 1'b0,
						bandwidth: one_lt ? p1_q : p2_q, last: 1'b1};
				end else if (any_term) begin
					push.item0 = '{out_kind: KIND_TERM, probe_slot: 1'b0, bandwidth: '0,
						last: 1'b1};
				end else begin
					push.item0 = '{out_kind: KIND_STOPPED, probe_slot: 1'b0, bandwidth: '0,
						last: 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			p1_q <= '0;
			p2_q <= '0;
			c1_q <= CRIT_MAX;
			c2_q <= CRIT_MAX;
			step_q <= '0;
			iter_q <= '0;
			s1_q <= ST_SUCCESS;
			s2_q <= ST_SUCCESS;
			pend_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				if (is_start) begin
					step_q <= step_new;
					p1_q <= floor_res;
					p2_q <= round_res;
					c1_q <= CRIT_MAX;
					c2_q <= CRIT_MAX;
					iter_q <= '0;
					s1_q <= ST_SUCCESS;
					s2_q <= ST_SUCCESS;
					pend_q <= 1'b0;
				end else begin
					c1_q <= (advance && !one_lt) ? c2_e : c1_e;
					c2_q <= (advance && one_lt) ? c1_e : c2_e;
					s1_q <= s1_e;
					s2_q <= s2_e;
					iter_q <= iter_e;
					if (phase_q == PH_INIT_A) begin
						pend_q <= 1'b1;
					end else if (advance) begin
						pend_q <= !one_lt;
					end
					if (advance) begin
						step_q <= step_new;
						if (one_lt) begin
							p2_q <= p1_q;
							p1_q <= round_res;
						end else begin
							p1_q <= p2_q;
							p2_q <= floor_res;
						end
					end
				end
			end
		end
	end

endmodule
